[rtl/linear_chirp_sample_generator_macros.svh]
// Assertion macros for the linear chirp sample generator.
// Expects clk and rst_n in the including module's scope.
`ifndef LINEAR_CHIRP_SAMPLE_GENERATOR_MACROS_SVH
`define LINEAR_CHIRP_SAMPLE_GENERATOR_MACROS_SVH

// same-cycle implication
`define LCSG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lcsg_pkg.sv]
// Shared constants, types and series tables for the chirp sample generator.
// No dependencies.
`default_nettype none

package lcsg_pkg;

    localparam int PHASE_BITS  = 48;
    localparam int INDEX_BITS  = 24;
    localparam int SAMPLE_BITS = 16;
    localparam int OFFSET_BITS = 16;
    localparam int AMP_BITS    = 15;
    localparam int CFG_BITS    = 48;
    localparam int CFG_IDX_BITS = 3;
    localparam int HALF_PHASE  = PHASE_BITS / 2;
    localparam int TERMS       = 7;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] Q30_ONE     = 32'h4000_0000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WINDOW_START   = 3'd0,
        REG_WINDOW_STOP    = 3'd1,
        REG_LINEAR_STEP    = 3'd2,
        REG_QUADRATIC_STEP = 3'd3,
        REG_PHASE_OFFSET   = 3'd4,
        REG_AMPLITUDE      = 3'd5
    } cfg_reg_t;

    // word handed from cell to cell
    typedef struct packed {
        logic               vld;
        logic               win;
        logic               qneg;
        logic [31:0]        t2;
        logic [31:0]        term;
        logic signed [32:0] sum;
    } lcsg_cell_t;

    // divisor (2n-1)(2n) of series term n
    function automatic logic [7:0] term_div(input logic [2:0] n);
        logic [7:0] d;
        begin
            case (n)
                3'd1:    d = 8'd2;
                3'd2:    d = 8'd12;
                3'd3:    d = 8'd30;
                3'd4:    d = 8'd56;
                3'd5:    d = 8'd90;
                3'd6:    d = 8'd132;
                3'd7:    d = 8'd182;
                default: d = 8'd1;
            endcase
            return d;
        end
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] term_recip(input logic [2:0] n);
        logic [31:0] m;
        begin
            case (n)
                3'd1:    m = 32'd2147483648;
                3'd2:    m = 32'd357913941;
                3'd3:    m = 32'd143165576;
                3'd4:    m = 32'd76695844;
                3'd5:    m = 32'd47721858;
                3'd6:    m = 32'd32537631;
                3'd7:    m = 32'd23598721;
                default: m = 32'hFFFF_FFFF;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/lcsg_phase.sv]
// Front end: window test, wrapped chirp phase, quadrant fold and t^2.
// Depends on lcsg_pkg.
`default_nettype none

module lcsg_phase
    import lcsg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   in_valid,
    input  wire logic [INDEX_BITS-1:0]  sample_index,
    input  wire logic [INDEX_BITS-1:0]  window_start,
    input  wire logic [INDEX_BITS-1:0]  window_stop,
    input  wire logic [PHASE_BITS-1:0]  linear_step,
    input  wire logic [PHASE_BITS-1:0]  quadratic_step,
    input  wire logic [OFFSET_BITS-1:0] phase_offset,
    output lcsg_cell_t                  cell_out
);

    logic [5:0] vld_reg, vld_next;
    logic [5:0] win_reg, win_next;

    logic [INDEX_BITS-1:0] k_reg, k_next;
    logic [PHASE_BITS-1:0] kk_reg, kk_next;
    logic [PHASE_BITS-1:0] lin_lo_reg, lin_lo_next;
    logic [HALF_PHASE-1:0] lin_hi_reg, lin_hi_next;
    logic [PHASE_BITS-1:0] pp0_reg, pp0_next;
    logic [HALF_PHASE-1:0] pp1_reg, pp1_next;
    logic [HALF_PHASE-1:0] pp2_reg, pp2_next;
    logic [PHASE_BITS-1:0] lin_reg, lin_next;
    logic [30:0]           x_reg, x_next;
    logic                  qn3_reg, qn3_next;
    logic                  qn4_reg, qn4_next;
    logic [30:0]           t_reg, t_next;
    logic [31:0]           t2_reg, t2_next;
    logic                  qn5_reg, qn5_next;

    logic [PHASE_BITS-1:0] ph;
    logic [1:0]            quad;
    logic [29:0]           rfrac;

    always_comb
    begin
        vld_next = {vld_reg[4:0], in_valid};
        win_next = {win_reg[4:0],
                    (sample_index >= window_start) && (sample_index <= window_stop)};
        k_next   = sample_index - window_start;

        kk_next     = PHASE_BITS'(k_reg) * PHASE_BITS'(k_reg);
        lin_lo_next = PHASE_BITS'(linear_step[HALF_PHASE-1:0]) * PHASE_BITS'(k_reg);
        lin_hi_next = HALF_PHASE'(PHASE_BITS'(linear_step[PHASE_BITS-1:HALF_PHASE])
                                  * PHASE_BITS'(k_reg));

        pp0_next = PHASE_BITS'(quadratic_step[HALF_PHASE-1:0])
                   * PHASE_BITS'(kk_reg[HALF_PHASE-1:0]);
        pp1_next = HALF_PHASE'(PHASE_BITS'(quadratic_step[HALF_PHASE-1:0])
                               * PHASE_BITS'(kk_reg[PHASE_BITS-1:HALF_PHASE]));
        pp2_next = HALF_PHASE'(PHASE_BITS'(quadratic_step[PHASE_BITS-1:HALF_PHASE])
                               * PHASE_BITS'(kk_reg[HALF_PHASE-1:0]));
        lin_next = lin_lo_reg + {lin_hi_reg, {HALF_PHASE{1'b0}}};

        ph = pp0_reg + {pp1_reg + pp2_reg, {HALF_PHASE{1'b0}}} + lin_reg
             + {phase_offset, {(PHASE_BITS-OFFSET_BITS){1'b0}}};
        quad  = ph[PHASE_BITS-1 -: 2];
        rfrac = ph[PHASE_BITS-3 -: 30];
        // odd quadrants mirror the angle
        x_next   = quad[0] ? (31'(Q30_ONE) - {1'b0, rfrac}) : {1'b0, rfrac};
        qn3_next = quad[1] ^ quad[0];

        t_next   = 31'((62'(x_reg) * 62'(HALF_PI_Q30)) >> 30);
        qn4_next = qn3_reg;

        t2_next  = 32'((64'(t_reg) * 64'(t_reg)) >> 30);
        qn5_next = qn4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win_reg    <= win_next;
            k_reg      <= k_next;
            kk_reg     <= kk_next;
            lin_lo_reg <= lin_lo_next;
            lin_hi_reg <= lin_hi_next;
            pp0_reg    <= pp0_next;
            pp1_reg    <= pp1_next;
            pp2_reg    <= pp2_next;
            lin_reg    <= lin_next;
            x_reg      <= x_next;
            qn3_reg    <= qn3_next;
            t_reg      <= t_next;
            qn4_reg    <= qn4_next;
            t2_reg     <= t2_next;
            qn5_reg    <= qn5_next;
        end
    end

    always_comb
    begin
        cell_out.vld  = vld_reg[5];
        cell_out.win  = win_reg[5];
        cell_out.qneg = qn5_reg;
        cell_out.t2   = t2_reg;
        cell_out.term = Q30_ONE;
        cell_out.sum  = 33'(Q30_ONE);
    end

endmodule

`default_nettype wire

[rtl/lcsg_term_cell.sv]
// One Taylor term cell: multiply by t^2, divide by a constant, accumulate.
// Depends on lcsg_pkg.
`default_nettype none

module lcsg_term_cell
    import lcsg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       adv,
    input  wire logic [2:0] term_num,
    input  lcsg_cell_t      cell_in,
    output lcsg_cell_t      cell_out
);

    logic [2:0] vld_reg, vld_next;

    logic               a_win_reg, b_win_reg;
    logic               a_qneg_reg, b_qneg_reg;
    logic [31:0]        a_t2_reg, b_t2_reg;
    logic signed [32:0] a_sum_reg, b_sum_reg;
    logic [31:0]        a_v_reg, a_v_next;
    logic [31:0]        b_v_reg;
    logic [31:0]        b_q_reg, b_q_next;
    lcsg_cell_t         c_reg, c_next;

    logic [7:0]  div;
    logic [39:0] qd;
    logic [39:0] rem;
    logic [31:0] qfix;

    always_comb
    begin
        div      = term_div(term_num);
        vld_next = {vld_reg[1:0], cell_in.vld};
        a_v_next = 32'((64'(cell_in.term) * 64'(cell_in.t2)) >> 30);
        // reciprocal estimate, low by at most one
        b_q_next = 32'((64'(a_v_reg) * 64'(term_recip(term_num))) >> 32);
        qd       = 40'(b_q_reg) * 40'(div);
        rem      = 40'(b_v_reg) - qd;
        qfix     = (rem >= 40'(div)) ? b_q_reg + 32'd1 : b_q_reg;

        c_next.vld  = vld_reg[1];
        c_next.win  = b_win_reg;
        c_next.qneg = b_qneg_reg;
        c_next.t2   = b_t2_reg;
        c_next.term = qfix;
        c_next.sum  = term_num[0] ? b_sum_reg - $signed({1'b0, qfix})
                                  : b_sum_reg + $signed({1'b0, qfix});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_win_reg  <= cell_in.win;
            a_qneg_reg <= cell_in.qneg;
            a_t2_reg   <= cell_in.t2;
            a_sum_reg  <= cell_in.sum;
            a_v_reg    <= a_v_next;
            b_win_reg  <= a_win_reg;
            b_qneg_reg <= a_qneg_reg;
            b_t2_reg   <= a_t2_reg;
            b_sum_reg  <= a_sum_reg;
            b_v_reg    <= a_v_reg;
            b_q_reg    <= b_q_next;
            c_reg      <= c_next;
        end
    end

    always_comb
    begin
        cell_out     = c_reg;
        cell_out.vld = vld_reg[2];
    end

endmodule

`default_nettype wire

[rtl/lcsg_scale.sv]
// Output stage: amplitude scaling with rounding, saturation, sign and window gate.
// Depends on lcsg_pkg.
`default_nettype none

module lcsg_scale
    import lcsg_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic [AMP_BITS-1:0]        amplitude,
    input  lcsg_cell_t                      cell_in,
    output logic                            out_valid,
    output logic signed [SAMPLE_BITS-1:0]   sample_value,
    output logic                            in_window
);

    localparam int OUT_SHIFT = 46 - SAMPLE_BITS;
    localparam int PROD_BITS = AMP_BITS + 32;

    logic [1:0] vld_reg, vld_next;

    logic [PROD_BITS-1:0] prod_reg, prod_next;
    logic                 neg_reg, neg_next;
    logic                 win_reg;
    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic                 win_o_reg;

    logic [31:0]          mag_in;
    logic [PROD_BITS-1:0] rnd;
    logic [SAMPLE_BITS-1:0] mag;

    always_comb
    begin
        vld_next  = {vld_reg[0], cell_in.vld};
        neg_next  = cell_in.qneg ^ cell_in.sum[32];
        mag_in    = cell_in.sum[32] ? 32'(-cell_in.sum) : 32'(cell_in.sum);
        prod_next = PROD_BITS'(amplitude) * PROD_BITS'(mag_in);

        rnd = (prod_reg + (PROD_BITS'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        if (rnd > PROD_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}}))
            mag = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else
            mag = SAMPLE_BITS'(rnd);

        if (!win_reg)
            val_next = '0;
        else if (neg_reg)
            val_next = $signed(-mag);
        else
            val_next = $signed(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            neg_reg   <= neg_next;
            win_reg   <= cell_in.win;
            val_reg   <= val_next;
            win_o_reg <= win_reg;
        end
    end

    assign out_valid    = vld_reg[1];
    assign sample_value = val_reg;
    assign in_window    = win_o_reg;

endmodule

`default_nettype wire

[rtl/linear_chirp_sample_generator.sv]
// Top level of the linear chirp sample generator: config registers and cell chain.
// Depends on lcsg_pkg, lcsg_phase, lcsg_term_cell, lcsg_scale and the macro header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | sink      | in_valid / in_stall  | sample_index
//   out     | source    | out_valid / out_stall| sample_value, in_window
//   cfg     | sink      | cfg_write_enable     | cfg_index, cfg_data
//
// One word in and one word out per cycle while not stalled; six front stages,
// seven term cells of three stages each, two output stages.
// The whole pipeline moves together; it holds only while out_valid is high and
// out_stall is asserted, and in_stall mirrors that condition.
// Reset clears the config registers and all stage valid bits.
`default_nettype none
`include "linear_chirp_sample_generator_macros.svh"

module linear_chirp_sample_generator
    import lcsg_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [INDEX_BITS-1:0]      sample_index,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [SAMPLE_BITS-1:0]   sample_value,
    output logic                            in_window,
    input  wire logic                       cfg_write_enable,
    input  wire logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [CFG_BITS-1:0]        cfg_data
);

    logic [INDEX_BITS-1:0]  window_start_reg;
    logic [INDEX_BITS-1:0]  window_stop_reg;
    logic [PHASE_BITS-1:0]  linear_step_reg;
    logic [PHASE_BITS-1:0]  quadratic_step_reg;
    logic [OFFSET_BITS-1:0] phase_offset_reg;
    logic [AMP_BITS-1:0]    amplitude_reg;

    logic       adv;
    lcsg_cell_t chain [TERMS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg   <= '0;
            window_stop_reg    <= '0;
            linear_step_reg    <= '0;
            quadratic_step_reg <= '0;
            phase_offset_reg   <= '0;
            amplitude_reg      <= '0;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_WINDOW_START:   window_start_reg   <= cfg_data[INDEX_BITS-1:0];
                REG_WINDOW_STOP:    window_stop_reg    <= cfg_data[INDEX_BITS-1:0];
                REG_LINEAR_STEP:    linear_step_reg    <= cfg_data[PHASE_BITS-1:0];
                REG_QUADRATIC_STEP: quadratic_step_reg <= cfg_data[PHASE_BITS-1:0];
                REG_PHASE_OFFSET:   phase_offset_reg   <= cfg_data[OFFSET_BITS-1:0];
                REG_AMPLITUDE:      amplitude_reg      <= cfg_data[AMP_BITS-1:0];
                default:            ;
            endcase
        end
    end

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    lcsg_phase u_phase (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_valid       (in_valid),
        .sample_index   (sample_index),
        .window_start   (window_start_reg),
        .window_stop    (window_stop_reg),
        .linear_step    (linear_step_reg),
        .quadratic_step (quadratic_step_reg),
        .phase_offset   (phase_offset_reg),
        .cell_out       (chain[0])
    );

    for (genvar g = 0; g < TERMS; g++)
    begin : g_term
        lcsg_term_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .term_num (3'(g + 1)),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    lcsg_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .amplitude    (amplitude_reg),
        .cell_in      (chain[TERMS]),
        .out_valid    (out_valid),
        .sample_value (sample_value),
        .in_window    (in_window)
    );

    `LCSG_ASSERT_IMPL(a_zero_outside, out_valid && !in_window, sample_value == '0, "sample outside window not zero")
    `LCSG_ASSERT_IMPL(a_no_neg_full, out_valid, sample_value != {1'b1, {(SAMPLE_BITS-1){1'b0}}}, "sample exceeds saturation")
    `LCSG_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output back-pressure")
    `LCSG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for linear_chirp_sample_generator: a predictor of the chirp
// sample, directed and random index words under varied idling. Depends on lcsg_pkg and the RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lcsg_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [23:0] INDEX_MAX = 24'hFF_FFFF;
    localparam logic [47:0] PHASE_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          win;
    } chirp_word_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [INDEX_BITS-1:0]         sample_index;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          in_window;
    logic                          cfg_write_enable;
    logic [CFG_IDX_BITS-1:0]       cfg_index;
    logic [CFG_BITS-1:0]           cfg_data;

    // shadow copy of the register file
    logic [23:0] win_start, win_stop;
    logic [47:0] lin_step, quad_step;
    logic [15:0] ph_offset;
    logic [14:0] amp;

    chirp_word_t pending_samples[$];
    int          mismatches;
    int          words_sent;
    int          words_checked;
    int          gap_pct;
    int          stall_pct;
    longint      cycles;

    linear_chirp_sample_generator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample_index     (sample_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sample_value     (sample_value),
        .in_window        (in_window),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Taylor series cosine of x/2^30 quarter turns, Q30
    function automatic longint quarter_turn_cos(input logic [63:0] x);
        logic [63:0] t, t2, term;
        longint      acc;
        begin
            t = (x * 64'd1686629713) >> 30;
            t2 = (t * t) >> 30;
            term = 64'd1 << 30;
            acc = longint'(64'd1 << 30);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                    acc -= longint'(term);
                else
                    acc += longint'(term);
            end
            return acc;
        end
    endfunction

    function automatic chirp_word_t chirp_sample(input logic [23:0] idx);
        chirp_word_t w;
        logic [63:0] k, ph, mag;
        logic [31:0] u;
        logic [1:0]  quad;
        logic [29:0] r;
        longint      c;
        logic        neg;
        begin
            w = '0;
            if (idx < win_start || idx > win_stop)
                return w;
            k = 64'(idx) - 64'(win_start);
            ph = 64'(quad_step) * (k * k) + 64'(lin_step) * k + (64'(ph_offset) << 32);
            u = ph[47:16];
            quad = u[31:30];
            r = u[29:0];
            c = quad[0] ? quarter_turn_cos((64'd1 << 30) - 64'(r)) : quarter_turn_cos(64'(r));
            neg = (quad == 2'd1 || quad == 2'd2);
            if (c < 0)
            begin
                neg = !neg;
                c = -c;
            end
            mag = (64'(amp) * 64'(c) + (64'd1 << 29)) >> 30;
            if (mag > 64'd32767)
                mag = 64'd32767;
            w.value = neg ? -16'(mag) : 16'(mag);
            w.win = 1'b1;
            return w;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("MISMATCH %s: got %0d expected %0d (word %0d)", what, got, want,
                     words_checked);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        chirp_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
                report_mismatch("unexpected word", sample_value, 0);
            else
            begin
                want = pending_samples.pop_front();
                if (sample_value !== want.value)
                    report_mismatch("sample_value", sample_value, want.value);
                if (in_window !== want.win)
                    report_mismatch("in_window", in_window, want.win);
            end
            words_checked++;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_index(input logic [23:0] idx);
        begin
            while ($urandom_range(0, 99) < gap_pct)
            begin
                in_valid <= 1'b0;
                sample_index <= 24'($urandom);
                @(posedge clk);
            end
            in_valid <= 1'b1;
            sample_index <= idx;
            do
                @(posedge clk);
            while (in_stall);
            pending_samples.push_back(chirp_sample(idx));
            words_sent++;
        end
    endtask

    // block must be drained before the register file changes
    task automatic wait_drained;
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending_samples.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // leaves the write enable high; caller ends the batch with end_writes
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [47:0] data);
        begin
            cfg_write_enable <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            case (idx)
                REG_WINDOW_START:   win_start = data[23:0];
                REG_WINDOW_STOP:    win_stop = data[23:0];
                REG_LINEAR_STEP:    lin_step = data;
                REG_QUADRATIC_STEP: quad_step = data;
                REG_PHASE_OFFSET:   ph_offset = data[15:0];
                REG_AMPLITUDE:      amp = data[14:0];
                default:            ;
            endcase
            @(posedge clk);
        end
    endtask

    task automatic end_writes;
        begin
            cfg_write_enable <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic load_config(input logic [23:0] s, input logic [23:0] e,
                               input logic [47:0] ls, input logic [47:0] qs,
                               input logic [15:0] po, input logic [14:0] a);
        begin
            wait_drained();
            // junk above each register's width must be dropped
            write_reg(REG_WINDOW_START, {24'($urandom), s});
            write_reg(REG_WINDOW_STOP, {24'($urandom), e});
            write_reg(REG_LINEAR_STEP, ls);
            write_reg(REG_QUADRATIC_STEP, qs);
            write_reg(REG_PHASE_OFFSET, {32'($urandom), po});
            write_reg(REG_AMPLITUDE, {33'($urandom), a});
            end_writes();
        end
    endtask

    task automatic test_reset_state;
        begin
            // zero amplitude, window 0..0
            send_index(24'd0);
            send_index(24'd1);
            send_index(INDEX_MAX);
        end
    endtask

    task automatic test_quadrants;
        begin
            load_config(24'd0, INDEX_MAX, 48'd0, 48'd0, 16'd0, 15'h7FFF);
            send_index(24'd0);
            send_index(INDEX_MAX);
            for (int q = 0; q < 5; q++)
            begin
                load_config(24'd0, INDEX_MAX, 48'd0, 48'd0,
                            (q == 4) ? 16'hFFFF : 16'(q * 16'h4000), 15'h7FFF);
                send_index(24'd5);
            end
        end
    endtask

    task automatic test_extremes;
        begin
            load_config(24'd0, INDEX_MAX, PHASE_MAX, PHASE_MAX, 16'hFFFF, 15'h7FFF);
            send_index(INDEX_MAX);
            send_index(24'd1);
            send_index(24'h80_0000);
            // empty window
            load_config(24'd100, 24'd99, 48'h1234_5678, 48'd77, 16'd0, 15'h7FFF);
            send_index(24'd99);
            send_index(24'd100);
            // window at the very top
            load_config(INDEX_MAX, INDEX_MAX, 48'h1, 48'h1, 16'h1234, 15'd1);
            send_index(INDEX_MAX);
            send_index(INDEX_MAX - 24'd1);
            // zero amplitude inside a wide window
            load_config(24'd10, 24'd20, 48'hABC_DEF0_1234, 48'h55, 16'h4321, 15'd0);
            send_index(24'd9);
            send_index(24'd15);
            send_index(24'd21);
        end
    endtask

    task automatic test_spare_index;
        begin
            load_config(24'd0, 24'd1000, 48'h10_0000_0000, 48'd0, 16'd0, 15'd20000);
            write_reg(REG_SPARE_LO, 48'hFFFF_FFFF_FFFF);
            write_reg(REG_SPARE_HI, 48'hFFFF_FFFF_FFFF);
            end_writes();
            send_index(24'd0);
            send_index(24'd3);
        end
    endtask

    task automatic test_random_chirps(input int chunks, input int per_chunk);
        logic [23:0] s, e, idx;
        logic [47:0] qs;
        begin
            for (int c = 0; c < chunks; c++)
            begin
                case (c % 4)
                    0: begin gap_pct = 0;  stall_pct = 0;  end
                    1: begin gap_pct = 55; stall_pct = 0;  end
                    2: begin gap_pct = 0;  stall_pct = 55; end
                    default: begin gap_pct = 7; stall_pct = 7; end
                endcase
                s = (c % 5 == 4) ? INDEX_MAX - 24'($urandom_range(0, 400)) : 24'($urandom);
                e = (25'(s) + 25'($urandom_range(0, 400)) > 25'(INDEX_MAX)) ? INDEX_MAX
                    : s + 24'($urandom_range(0, 400));
                if (c % 7 == 6)
                    e = s - 24'd1;
                // small chirp rates mostly, occasionally anything
                qs = (c % 3 == 0) ? {$urandom, 16'($urandom)} : 48'($urandom_range(0, 1 << 20));
                load_config(s, e, {$urandom, 16'($urandom)}, qs, 16'($urandom),
                            (c % 6 == 5) ? 15'h7FFF : 15'($urandom));
                for (int i = 0; i < per_chunk; i++)
                begin
                    if ($urandom_range(0, 99) < 80)
                        idx = s + 24'($urandom_range(0, 420)) - 24'd10;
                    else
                        idx = 24'($urandom);
                    send_index(idx);
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_index = '0;
        out_stall = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        win_start = '0;
        win_stop = '0;
        lin_step = '0;
        quad_step = '0;
        ph_offset = '0;
        amp = '0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        gap_pct = 0;
        stall_pct = 0;
        cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_quadrants();
        test_extremes();
        test_spare_index();
        test_random_chirps(24, 68);

        wait_drained();
        $display("%0d index words sent, %0d samples checked over 24 random register sets",
                 words_sent, words_checked);
        $display("covering quadrants, extremes, empty windows and all idling mixes");
        if (mismatches == 0 && pending_samples.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

`default_nettype wire
